/* hdl/cbe_pkg.sv */
// shared constants, register codes and result type for the cross erosion block
package cbe_pkg;

	// field widths
	localparam int COL_W    = 12;
	localparam int ROW_W    = 16;
	localparam int WIDTH_W  = 13;
	localparam int HEIGHT_W = 16;

	// configuration channel
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1
	} cfg_reg_t;

	// register reset values
	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 13'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;

	// line store depth and the smallest frame side with an interior
	localparam int MAX_WIDTH_DEFAULT = 4096;
	localparam int MIN_DIM           = 3;

	// one result item
	typedef struct packed {
		logic             interior;
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] row;
		logic             frame_last;
	} result_t;

endpackage

/* hdl/cbe_if.sv */
// channel interfaces: pixel input, result output, configuration writes

interface cbe_pixel_if;
	logic valid;
	logic ready;
	logic foreground;

	modport source (output valid, output foreground, input ready);
	modport sink   (input valid, input foreground, output ready);
endinterface

interface cbe_result_if;
	import cbe_pkg::*;

	logic             valid;
	logic             ready;
	logic             interior;
	logic [COL_W-1:0] column;
	logic [ROW_W-1:0] row;
	logic             frame_last;

	modport source (output valid, output interior, output column, output row,
		output frame_last, input ready);
	modport sink   (input valid, input interior, input column, input row,
		input frame_last, output ready);
endinterface

interface cbe_cfg_if;
	import cbe_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/cbe_line_store.sv */
// two one-bit line memories with registered read ports for the rows above
module cbe_line_store #(
	parameter int MAX_WIDTH = cbe_pkg::MAX_WIDTH_DEFAULT,
	parameter int AW        = $clog2(MAX_WIDTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic          south,
	input  logic [AW-1:0] rd_addr,
	input  logic [AW-1:0] rd_addr_east,
	output logic          above_q,
	output logic          north_q,
	output logic          east_q
);
	import cbe_pkg::*;

	logic row_one_mem [MAX_WIDTH];
	logic row_two_mem [MAX_WIDTH];

	// row one takes the new pixel, row two takes what row one held there
	always_ff @(posedge clk) begin
		if (wr_en) begin
			row_one_mem[wr_addr] <= south;
			row_two_mem[wr_addr] <= above_q;
		end
	end

	// read ahead at the column of the next item
	always_ff @(posedge clk) begin
		above_q <= row_one_mem[rd_addr];
		east_q  <= row_one_mem[rd_addr_east];
		north_q <= row_two_mem[rd_addr];
	end

endmodule

/* hdl/cbe_result_fifo.sv */
// small result queue taking up to two items per cycle and giving one
module cbe_result_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push0,
	input  cbe_pkg::result_t  data0,
	input  logic              push1,
	input  cbe_pkg::result_t  data1,
	output logic              room2,
	output logic              out_valid,
	input  logic              out_ready,
	output cbe_pkg::result_t  out_data
);
	import cbe_pkg::*;

	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = PW + 1;

	result_t         entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            pop;
	logic [CW-1:0]   n_push;

	assign pop       = out_valid && out_ready;
	assign out_valid = count_q != '0;
	assign out_data  = entry_q[rd_ptr_q];
	assign room2     = count_q <= CW'(DEPTH - 2);
	assign n_push    = CW'(push0) + CW'(push1);

	// entry storage
	always_ff @(posedge clk) begin
		if (push0) begin
			entry_q[wr_ptr_q] <= data0;
		end
		if (push1) begin
			entry_q[wr_ptr_q + PW'(1)] <= data1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push[PW-1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			count_q <= count_q + n_push - CW'(pop);
		end
	end

endmodule

/* hdl/binary_cross_erosion_core.sv */
// Cross-shaped 3x3 binary erosion of a raster pixel stream. One foreground bit is
// taken per item, left to right and top to bottom; each result item tells whether
// all four orthogonal neighbours of a pixel are foreground, with the frame border
// and any frame narrower or shorter than 3 giving 0, and carries the pixel's
// column, row and an end-of-frame mark on the last pixel. Row 0 comes out as it
// arrives, each middle row comes out while the row below it arrives, and the last
// row is interleaved with the row above it. A pixel is taken every clock while the
// output queue has room for two results; its results are queued as it is taken.
// Each last-row pixel yields two results, so the single result port sets the pace.
// Two MAX_WIDTH x 1 line memories, read one column ahead, hold the two previous
// rows. The user must write frame size via the configuration channel between
// frames, unchecked by the core; line data is invalid until the first rows pass.
module binary_cross_erosion_core #(
	parameter int MAX_WIDTH = cbe_pkg::MAX_WIDTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	cbe_pixel_if.sink   pixel,
	cbe_result_if.source result,
	cbe_cfg_if.sink     cfg
);
	import cbe_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int EW = (WIDTH_W > AW + 1) ? WIDTH_W : AW + 1;
	localparam int HW = HEIGHT_W + 1;

	// column to line memory address, last entry for columns past the end
	function automatic logic [AW-1:0] col_addr(input logic [EW-1:0] col);
		logic [AW-1:0] addr;
		if (col >= EW'(MAX_WIDTH)) begin
			addr = AW'(MAX_WIDTH - 1);
		end else begin
			addr = col[AW-1:0];
		end
		return addr;
	endfunction

	logic [WIDTH_W-1:0]  frame_width_q;
	logic [HEIGHT_W-1:0] frame_height_q;
	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    row_q;
	logic                west_q;

	logic [EW-1:0]    w_eff;
	logic [HW-1:0]    h_eff;
	logic [EW-1:0]    col_ext;
	logic [EW-1:0]    col_inc;
	logic [HW-1:0]    row_inc;
	logic             row_end;
	logic             frame_end;
	logic             small_frame;
	logic             interior_ok;
	logic [COL_W-1:0] col_next;
	logic [COL_W-1:0] rd_col;
	logic             accept;
	logic             fifo_room2;
	logic             above;
	logic             north;
	logic             east;
	logic             has_mid;
	logic             has_edge;
	result_t          mid_res;
	result_t          edge_res;
	result_t          out_data;
	logic             push0;
	logic             push1;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WIDTH_RESET;
			frame_height_q <= HEIGHT_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg.data[WIDTH_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg.data[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// effective frame size
	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = EW'(1);
		end else if (EW'(frame_width_q) > EW'(MAX_WIDTH)) begin
			w_eff = EW'(MAX_WIDTH);
		end else begin
			w_eff = EW'(frame_width_q);
		end
		h_eff = (frame_height_q == '0) ? HW'(1) : HW'(frame_height_q);
	end

	// position decode
	assign accept      = pixel.valid && pixel.ready;
	assign col_ext     = EW'(col_q);
	assign col_inc     = col_ext + EW'(1);
	assign row_inc     = HW'(row_q) + HW'(1);
	assign row_end     = col_inc >= w_eff;
	assign frame_end   = row_end && (row_inc >= h_eff);
	assign small_frame = (w_eff < EW'(MIN_DIM)) || (h_eff < HW'(MIN_DIM));
	assign interior_ok = !small_frame && (col_q != '0) && (col_inc < w_eff)
		&& (col_inc < EW'(MAX_WIDTH));
	assign col_next    = row_end ? '0 : col_q + COL_W'(1);
	assign rd_col      = accept ? col_next : col_q;

	// line memories
	cbe_line_store #(
		.MAX_WIDTH (MAX_WIDTH),
		.AW        (AW)
	) u_line_store (
		.clk          (clk),
		.wr_en        (accept),
		.wr_addr      (col_addr(col_ext)),
		.south        (pixel.foreground),
		.rd_addr      (col_addr(EW'(rd_col))),
		.rd_addr_east (col_addr(EW'(rd_col) + EW'(1))),
		.above_q      (above),
		.north_q      (north),
		.east_q       (east)
	);

	// scan counters and the west neighbour
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			west_q <= 1'b0;
		end else if (accept) begin
			col_q <= col_next;
			if (row_end) begin
				west_q <= 1'b0;
				row_q  <= frame_end ? '0 : row_q + ROW_W'(1);
			end else begin
				west_q <= above;
			end
		end
	end

	// results for the row above and for the edge rows
	assign has_mid  = row_q >= ROW_W'(2);
	assign has_edge = (row_q == '0) || (row_inc >= h_eff);

	always_comb begin
		mid_res.interior   = interior_ok && north && pixel.foreground && west_q && east;
		mid_res.column     = col_q;
		mid_res.row        = row_q - ROW_W'(1);
		mid_res.frame_last = 1'b0;
		edge_res.interior   = 1'b0;
		edge_res.column     = col_q;
		edge_res.row        = row_q;
		edge_res.frame_last = frame_end;
	end

	assign push0 = accept && (has_mid || has_edge);
	assign push1 = accept && has_mid && has_edge;

	// output queue
	cbe_result_fifo u_result_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push0     (push0),
		.data0     (has_mid ? mid_res : edge_res),
		.push1     (push1),
		.data1     (edge_res),
		.room2     (fifo_room2),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (out_data)
	);

	assign pixel.ready       = fifo_room2;
	assign result.interior   = out_data.interior;
	assign result.column     = out_data.column;
	assign result.row        = out_data.row;
	assign result.frame_last = out_data.frame_last;

endmodule
